### hw/rtl/lcm_pkg.sv
`timescale 1ns / 1ps

package lcm_pkg;

    // Capacity and coordinate format
    localparam int MaxLines   = 16;
    localparam int CoordBits  = 12;
    localparam int MaxCorners = 64;

    // Register formats
    localparam int TanBits  = 11;
    localparam int DistBits = 25;
    localparam int TanFrac  = 10;
    localparam int CfgW     = (DistBits > TanBits) ? DistBits : TanBits;
    localparam int CfgIdxW  = 1;

    localparam logic [DistBits-1:0] DistReset = DistBits'(625);
    localparam logic [TanBits-1:0]  TanReset  = TanBits'(373);

    // Register indexes
    localparam logic [CfgIdxW-1:0] RegCornerDistSq = 1'b0;
    localparam logic [CfgIdxW-1:0] RegAngleTanQ10  = 1'b1;

    // Request codes
    localparam logic ReqLoad   = 1'b0;
    localparam logic ReqFinish = 1'b1;

    // Derived widths
    localparam int LineIdxW   = (MaxLines > 1) ? $clog2(MaxLines) : 1;
    localparam int LineCntW   = $clog2(MaxLines + 1);
    localparam int CornerCntW = $clog2(MaxCorners + 1);
    localparam int MulW       = (CoordBits > TanBits) ? CoordBits : TanBits;
    localparam int ProdW      = 2 * MulW;
    localparam int SumW       = ProdW + 1;
    localparam int CmpW       = (SumW > DistBits) ? SumW : DistBits;

    typedef struct packed {
        logic [CoordBits-1:0] x1;
        logic [CoordBits-1:0] y1;
        logic [CoordBits-1:0] x2;
        logic [CoordBits-1:0] y2;
    } seg_t;

    localparam int SegW = $bits(seg_t);

    // Operands for the shared multiplier
    typedef struct packed {
        logic            en;
        logic [MulW-1:0] a;
        logic [MulW-1:0] b;
    } mul_req_t;

    function automatic logic [CoordBits-1:0] absdiff(
        input logic [CoordBits-1:0] p,
        input logic [CoordBits-1:0] q
    );
        return (p > q) ? (p - q) : (q - p);
    endfunction

endpackage

### hw/rtl/lcm_ram.sv
`timescale 1ns / 1ps

module lcm_ram #(
    parameter int Width = 8,
    parameter int Depth = 16,
    localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AddrW-1:0] wr_addr,
    input  logic [Width-1:0] wr_data,
    input  logic [AddrW-1:0] rd_addr,
    output logic [Width-1:0] rd_data
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### hw/rtl/lcm_mul.sv
`timescale 1ns / 1ps

module lcm_mul import lcm_pkg::*; (
    input  logic             clk,
    input  mul_req_t         req,
    output logic [ProdW-1:0] prod
);

    logic [ProdW-1:0] prod_reg;

    // Hold the product while not issued
    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg <= ProdW'(req.a) * ProdW'(req.b);
        end
    end

    assign prod = prod_reg;

endmodule

### hw/rtl/line_corner_matcher_top.sv
`timescale 1ns / 1ps

// Line corner matcher. Load words (req_type 0) classify a segment as
// horizontal or vertical against the tangent tolerance and store it in a
// 16-entry table; other segments are dropped. A finish word (req_type 1)
// pairs every horizontal with every vertical segment and returns one result
// word per corner (truncated midpoint of two endpoints closer than
// corner_dist_sq), or a single found=0 word when there is none; the final
// word carries last. Both tables are then cleared. All multiplications go
// through one shared 12x12 multiplier, and the block takes one word at a
// time. A load word is accepted, then passes S_LD_A and S_LD_B (tolerance
// products) and S_LD_C (table write). A finish word runs a counting pass
// that reads each horizontal/vertical pair and, for each of its four
// endpoint pairs, squares dx and dy and compares, then an emitting pass
// over the same order that stops at the last corner and holds while the
// result side stalls; with either table empty it goes straight to the
// found=0 word. A new word is accepted while the last result still waits.
module line_corner_matcher_top import lcm_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic                 req_type,
    input  logic [CoordBits-1:0] start_x,
    input  logic [CoordBits-1:0] start_y,
    input  logic [CoordBits-1:0] end_x,
    input  logic [CoordBits-1:0] end_y,

    input  logic                 cfg_we,
    input  logic [CfgIdxW-1:0]   cfg_index,
    input  logic [CfgW-1:0]      cfg_data,

    output logic                 result_valid,
    input  logic                 result_ready,
    output logic [CoordBits-1:0] corner_x,
    output logic [CoordBits-1:0] corner_y,
    output logic                 found,
    output logic                 overflow,
    output logic                 last
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_A,
        S_LD_B,
        S_LD_C,
        S_FN_RD,
        S_FN_DX,
        S_FN_DY,
        S_FN_CMP,
        S_FN_MARK
    } state_t;

    state_t                state_reg;
    seg_t                  seg_reg;
    logic                  horiz_reg;
    logic [LineCntW-1:0]   hcount_reg;
    logic [LineCntW-1:0]   vcount_reg;
    logic                  dropped_reg;
    logic [DistBits-1:0]   dist_reg;
    logic [TanBits-1:0]    tan_reg;
    logic [LineIdxW-1:0]   h_idx_reg;
    logic [LineIdxW-1:0]   v_idx_reg;
    logic [1:0]            ep_reg;
    logic                  emit_pass_reg;
    logic [CornerCntW-1:0] hit_cnt_reg;
    logic [CornerCntW-1:0] emit_cnt_reg;
    logic                  ovf_reg;
    logic [ProdW-1:0]      sq_reg;

    logic                  result_valid_reg;
    logic [CoordBits-1:0]  cx_reg;
    logic [CoordBits-1:0]  cy_reg;
    logic                  found_reg;
    logic                  last_reg;
    logic                  ovf_out_reg;

    seg_t                  h_rd;
    seg_t                  v_rd;
    logic [SegW-1:0]       h_rd_bits;
    logic [SegW-1:0]       v_rd_bits;
    logic                  h_we;
    logic                  v_we;

    mul_req_t              mul_req;
    logic [ProdW-1:0]      mul_prod;

    logic [CoordBits-1:0]  adx;
    logic [CoordBits-1:0]  ady;
    logic                  cmp_h;
    logic                  cmp_v;
    logic [CoordBits-1:0]  pax;
    logic [CoordBits-1:0]  pay;
    logic [CoordBits-1:0]  pbx;
    logic [CoordBits-1:0]  pby;
    logic [CoordBits-1:0]  dx;
    logic [CoordBits-1:0]  dy;
    logic [CoordBits:0]    sum_x;
    logic [CoordBits:0]    sum_y;
    logic [CmpW-1:0]       dist_sum;
    logic                  hit;
    logic                  emit_ok;
    logic                  emit_done;
    logic                  out_free;
    logic                  stall;
    logic                  result_load;
    logic                  last_ep;
    logic                  last_v;
    logic                  last_h;
    logic [CornerCntW-1:0] hit_cnt_next;

    // Segment tables
    assign h_we = (state_reg == S_LD_C) && horiz_reg
                  && (hcount_reg < LineCntW'(MaxLines));
    assign v_we = (state_reg == S_LD_C) && !horiz_reg && cmp_v
                  && (vcount_reg < LineCntW'(MaxLines));

    lcm_ram #(
        .Width (SegW),
        .Depth (MaxLines)
    ) u_horiz_ram (
        .clk     (clk),
        .we      (h_we),
        .wr_addr (hcount_reg[LineIdxW-1:0]),
        .wr_data (seg_reg),
        .rd_addr (h_idx_reg),
        .rd_data (h_rd_bits)
    );

    lcm_ram #(
        .Width (SegW),
        .Depth (MaxLines)
    ) u_vert_ram (
        .clk     (clk),
        .we      (v_we),
        .wr_addr (vcount_reg[LineIdxW-1:0]),
        .wr_data (seg_reg),
        .rd_addr (v_idx_reg),
        .rd_data (v_rd_bits)
    );

    assign h_rd = seg_t'(h_rd_bits);
    assign v_rd = seg_t'(v_rd_bits);

    // Classification operands
    assign adx = absdiff(seg_reg.x1, seg_reg.x2);
    assign ady = absdiff(seg_reg.y1, seg_reg.y2);

    // Endpoint pair: upper bit picks the horizontal end, lower the vertical
    assign pax = ep_reg[1] ? h_rd.x2 : h_rd.x1;
    assign pay = ep_reg[1] ? h_rd.y2 : h_rd.y1;
    assign pbx = ep_reg[0] ? v_rd.x2 : v_rd.x1;
    assign pby = ep_reg[0] ? v_rd.y2 : v_rd.y1;
    assign dx  = absdiff(pax, pbx);
    assign dy  = absdiff(pay, pby);

    always_comb
    begin
        mul_req.en = 1'b0;
        mul_req.a  = '0;
        mul_req.b  = '0;
        case (state_reg)
            S_LD_A:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = MulW'(tan_reg);
                mul_req.b  = MulW'(adx);
            end
            S_LD_B:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = MulW'(tan_reg);
                mul_req.b  = MulW'(ady);
            end
            S_FN_DX:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = MulW'(dx);
                mul_req.b  = MulW'(dx);
            end
            S_FN_DY:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = MulW'(dy);
                mul_req.b  = MulW'(dy);
            end
            default:
            begin
                mul_req.en = 1'b0;
            end
        endcase
    end

    lcm_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (mul_prod)
    );

    assign cmp_h = (ProdW'(ady) << TanFrac) < mul_prod;
    assign cmp_v = (ProdW'(adx) << TanFrac) < mul_prod;

    assign sum_x    = {1'b0, pax} + {1'b0, pbx};
    assign sum_y    = {1'b0, pay} + {1'b0, pby};
    assign dist_sum = CmpW'(sq_reg) + CmpW'(mul_prod);
    assign hit      = dist_sum < CmpW'(dist_reg);

    assign out_free  = !result_valid_reg || result_ready;
    assign emit_ok   = hit && emit_pass_reg && (emit_cnt_reg < hit_cnt_reg);
    assign emit_done = emit_ok && ((emit_cnt_reg + CornerCntW'(1)) == hit_cnt_reg);
    assign stall     = emit_ok && !out_free;

    // A new result word enters the output register this cycle
    assign result_load = ((state_reg == S_FN_CMP) && emit_ok && out_free)
                         || ((state_reg == S_FN_MARK) && out_free);

    assign last_ep = (ep_reg == 2'd3);
    assign last_v  = (LineCntW'(v_idx_reg) + LineCntW'(1)) == vcount_reg;
    assign last_h  = (LineCntW'(h_idx_reg) + LineCntW'(1)) == hcount_reg;

    assign hit_cnt_next = (hit && !emit_pass_reg
                           && (hit_cnt_reg < CornerCntW'(MaxCorners)))
                          ? hit_cnt_reg + CornerCntW'(1) : hit_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            seg_reg          <= '0;
            horiz_reg        <= 1'b0;
            hcount_reg       <= '0;
            vcount_reg       <= '0;
            dropped_reg      <= 1'b0;
            dist_reg         <= DistReset;
            tan_reg          <= TanReset;
            h_idx_reg        <= '0;
            v_idx_reg        <= '0;
            ep_reg           <= '0;
            emit_pass_reg    <= 1'b0;
            hit_cnt_reg      <= '0;
            emit_cnt_reg     <= '0;
            ovf_reg          <= 1'b0;
            sq_reg           <= '0;
            result_valid_reg <= 1'b0;
            cx_reg           <= '0;
            cy_reg           <= '0;
            found_reg        <= 1'b0;
            last_reg         <= 1'b0;
            ovf_out_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    RegCornerDistSq: dist_reg <= cfg_data[DistBits-1:0];
                    RegAngleTanQ10:  tan_reg  <= cfg_data[TanBits-1:0];
                    default:         dist_reg <= dist_reg;
                endcase
            end

            if (result_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && result_ready)
            begin
                result_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        if (req_type == ReqFinish)
                        begin
                            ovf_reg       <= dropped_reg;
                            hit_cnt_reg   <= '0;
                            emit_cnt_reg  <= '0;
                            emit_pass_reg <= 1'b0;
                            h_idx_reg     <= '0;
                            v_idx_reg     <= '0;
                            ep_reg        <= '0;
                            if ((hcount_reg == '0) || (vcount_reg == '0))
                            begin
                                state_reg <= S_FN_MARK;
                            end
                            else
                            begin
                                state_reg <= S_FN_RD;
                            end
                        end
                        else
                        begin
                            seg_reg.x1 <= start_x;
                            seg_reg.y1 <= start_y;
                            seg_reg.x2 <= end_x;
                            seg_reg.y2 <= end_y;
                            state_reg  <= S_LD_A;
                        end
                    end
                end

                S_LD_A:
                begin
                    state_reg <= S_LD_B;
                end

                S_LD_B:
                begin
                    horiz_reg <= cmp_h;
                    state_reg <= S_LD_C;
                end

                S_LD_C:
                begin
                    if (horiz_reg)
                    begin
                        if (hcount_reg < LineCntW'(MaxLines))
                        begin
                            hcount_reg <= hcount_reg + LineCntW'(1);
                        end
                        else
                        begin
                            dropped_reg <= 1'b1;
                        end
                    end
                    else if (cmp_v)
                    begin
                        if (vcount_reg < LineCntW'(MaxLines))
                        begin
                            vcount_reg <= vcount_reg + LineCntW'(1);
                        end
                        else
                        begin
                            dropped_reg <= 1'b1;
                        end
                    end
                    state_reg <= S_IDLE;
                end

                S_FN_RD:
                begin
                    state_reg <= S_FN_DX;
                end

                S_FN_DX:
                begin
                    state_reg <= S_FN_DY;
                end

                S_FN_DY:
                begin
                    sq_reg    <= mul_prod;
                    state_reg <= S_FN_CMP;
                end

                S_FN_CMP:
                begin
                    // Hold here while a corner waits for the output register
                    if (!stall)
                    begin
                        hit_cnt_reg <= hit_cnt_next;
                        if (hit && !emit_pass_reg
                            && (hit_cnt_reg >= CornerCntW'(MaxCorners)))
                        begin
                            ovf_reg <= 1'b1;
                        end

                        if (emit_ok)
                        begin
                            cx_reg       <= sum_x[CoordBits:1];
                            cy_reg       <= sum_y[CoordBits:1];
                            found_reg    <= 1'b1;
                            last_reg     <= emit_done;
                            ovf_out_reg  <= ovf_reg;
                            emit_cnt_reg <= emit_cnt_reg + CornerCntW'(1);
                        end

                        if (emit_done)
                        begin
                            hcount_reg  <= '0;
                            vcount_reg  <= '0;
                            dropped_reg <= 1'b0;
                            state_reg   <= S_IDLE;
                        end
                        else if (!last_ep)
                        begin
                            ep_reg    <= ep_reg + 2'd1;
                            state_reg <= S_FN_DX;
                        end
                        else
                        begin
                            ep_reg <= '0;
                            if (!last_v)
                            begin
                                v_idx_reg <= v_idx_reg + LineIdxW'(1);
                                state_reg <= S_FN_RD;
                            end
                            else if (!last_h)
                            begin
                                v_idx_reg <= '0;
                                h_idx_reg <= h_idx_reg + LineIdxW'(1);
                                state_reg <= S_FN_RD;
                            end
                            else if (!emit_pass_reg && (hit_cnt_next != '0))
                            begin
                                // Counting done: rescan and emit
                                v_idx_reg     <= '0;
                                h_idx_reg     <= '0;
                                emit_pass_reg <= 1'b1;
                                state_reg     <= S_FN_RD;
                            end
                            else if (!emit_pass_reg)
                            begin
                                state_reg <= S_FN_MARK;
                            end
                            else
                            begin
                                hcount_reg  <= '0;
                                vcount_reg  <= '0;
                                dropped_reg <= 1'b0;
                                state_reg   <= S_IDLE;
                            end
                        end
                    end
                end

                S_FN_MARK:
                begin
                    if (out_free)
                    begin
                        cx_reg      <= '0;
                        cy_reg      <= '0;
                        found_reg   <= 1'b0;
                        last_reg    <= 1'b1;
                        ovf_out_reg <= ovf_reg;
                        hcount_reg  <= '0;
                        vcount_reg  <= '0;
                        dropped_reg <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign corner_x     = cx_reg;
    assign corner_y     = cy_reg;
    assign found        = found_reg;
    assign overflow     = ovf_out_reg;
    assign last         = last_reg;

endmodule

### hw/rtl/lcm_checker.sv
`timescale 1ns / 1ps

module lcm_checker import lcm_pkg::*; (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 result_valid,
    input logic                 result_ready,
    input logic [CoordBits-1:0] corner_x,
    input logic [CoordBits-1:0] corner_y,
    input logic                 found,
    input logic                 overflow,
    input logic                 last
);

    logic in_frame_reg;
    logic frame_ovf_reg;

    // Track whether a finish word's results are still coming
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg  <= 1'b0;
            frame_ovf_reg <= 1'b0;
        end
        else if (result_valid && result_ready)
        begin
            in_frame_reg  <= !last;
            frame_ovf_reg <= overflow;
        end
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(corner_x)
            && $stable(corner_y) && $stable(found) && $stable(overflow)
            && $stable(last))
        else $error("result word changed while stalled");

    a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !found |-> last && (corner_x == '0) && (corner_y == '0))
        else $error("empty frame marker malformed");

    a_overflow_steady: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && in_frame_reg |-> overflow == frame_ovf_reg)
        else $error("overflow changed within one frame");

    a_no_marker_mid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && in_frame_reg |-> found)
        else $error("empty marker inside a corner list");

endmodule

bind line_corner_matcher_top lcm_checker u_lcm_checker (.*);
